@@ rtl/cbps_pkg.sv @@
// Shared constants, types and the curve setup function for the cubic Bezier stepper.
// No dependencies; every other file imports this package.
package cbps_pkg;

  localparam int STEPS      = 2000;
  localparam int COORD_BITS = 9;
  localparam int STEP_W     = 16;

  localparam longint unsigned N1 = 64'(STEPS);
  localparam longint unsigned N2 = N1 * N1;
  localparam longint unsigned N3 = N2 * N1;

  // Numerator 2*acc + N^3 of the rounded quotient, kept modulo 2^ACC_W.
  localparam int ACC_W = COORD_BITS + $clog2(N3) + 1;

  localparam int NUM_REGS = 8;
  localparam int IDX_W    = $clog2(NUM_REGS);
  localparam int ADDR_W   = IDX_W + 2;
  localparam int DATA_W   = 32;
  localparam int IN_W     = 8;
  localparam int OUT_W    = ((2 * COORD_BITS + STEP_W + 7) / 8) * 8;

  localparam logic [IDX_W-1:0] REG_X0 = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_X1 = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_X2 = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_X3 = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_Y0 = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_Y1 = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_Y2 = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_Y3 = IDX_W'(7);

  localparam logic [STEP_W-1:0] LAST_K = STEP_W'(STEPS - 1);

  typedef logic [ACC_W-1:0]      acc_t;
  typedef logic [COORD_BITS-1:0] coord_t;

  localparam acc_t K3    = ACC_W'(3);
  localparam acc_t K6    = ACC_W'(6);
  localparam acc_t K12   = ACC_W'(12);
  localparam acc_t K3N   = ACC_W'(3 * N1);
  localparam acc_t K3N2  = ACC_W'(3 * N2);
  localparam acc_t N3A   = ACC_W'(N3);

  // start values of one axis: doubled and offset accumulator plus doubled differences
  typedef struct packed {
    acc_t acc;
    acc_t d1;
    acc_t d2;
    acc_t d3;
  } axis_init_t;

  // what travels down the rounding row
  typedef struct packed {
    acc_t              rem_x;
    acc_t              rem_y;
    coord_t            q_x;
    coord_t            q_y;
    logic [STEP_W-1:0] step;
    logic              last;
  } div_lane_t;

  function automatic axis_init_t axis_init(coord_t p0, coord_t p1, coord_t p2, coord_t p3);
    acc_t e0, e1, e2, e3, a, b, c;
    axis_init_t r;
    e0 = ACC_W'(p0);
    e1 = ACC_W'(p1);
    e2 = ACC_W'(p2);
    e3 = ACC_W'(p3);
    // cubic a k^3 + b k^2 + c k + N^3 P0, two's complement wrap is harmless
    a = e3 + K3 * e1 - e0 - K3 * e2;
    b = K3N * (e0 + e2 - (e1 << 1));
    c = K3N2 * (e1 - e0);
    r.acc = ((N3A * e0) << 1) + N3A;
    r.d1  = (a + b + c) << 1;
    r.d2  = (K6 * a + (b << 1)) << 1;
    r.d3  = K12 * a;
    return r;
  endfunction

endpackage

@@ rtl/cbps_diff_cell.sv @@
// One forward-difference cell: holds a value and adds its neighbor's value on each step.
// Depends on cbps_pkg.
module cbps_diff_cell
  import cbps_pkg::*;
(
  input  logic clk,
  input  logic load,
  input  logic advance,
  input  acc_t init,
  input  acc_t nb_cur,
  output acc_t cur
);

  acc_t value;

  // at the start of a curve the cell shows its start value instead of the stored one
  assign cur = load ? init : value;

  always_ff @(posedge clk) begin
    if (advance) begin
      value <= cur + nb_cur;
    end
  end

endmodule

@@ rtl/cbps_div_cell.sv @@
// One restoring-division cell of the rounding row: yields one quotient bit per axis.
// Depends on cbps_pkg.
module cbps_div_cell
  import cbps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_lane_t in_lane,
  input  acc_t      divisor,
  output logic      out_valid,
  input  logic      out_ready,
  output div_lane_t out_lane
);

  logic [ACC_W:0] diff_x, diff_y;
  logic           ge_x, ge_y;
  div_lane_t      lane_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    diff_x = {1'b0, in_lane.rem_x} - {1'b0, divisor};
    diff_y = {1'b0, in_lane.rem_y} - {1'b0, divisor};
    ge_x   = !diff_x[ACC_W];
    ge_y   = !diff_y[ACC_W];
    lane_next       = in_lane;
    lane_next.rem_x = ge_x ? diff_x[ACC_W-1:0] : in_lane.rem_x;
    lane_next.rem_y = ge_y ? diff_y[ACC_W-1:0] : in_lane.rem_y;
    lane_next.q_x   = {in_lane.q_x[COORD_BITS-2:0], ge_x};
    lane_next.q_y   = {in_lane.q_y[COORD_BITS-2:0], ge_y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_lane <= lane_next;
    end
  end

endmodule

@@ rtl/cubic_bezier_point_stepper.sv @@
// Cubic Bezier point stepper: APB control points, difference cells, rounding row.
// Depends on cbps_pkg, cbps_diff_cell and cbps_div_cell.
//
// Each request advances the curve by one step (restart in tdata bit 0 returns to step 0)
// and yields one point, one request per clock while the row is not stalled. The step
// itself is one addition per difference cell; the rounded point then passes a row of
// COORD_BITS division cells, one quotient bit per cell, each registering the point.
// The row holds one point per cell and takes requests while the output waits until it
// is full. Control point writes take effect at the next start of a curve.
module cubic_bezier_point_stepper
  import cbps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // request stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // [0] restart, rest zero
  // point stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // point_x, point_y, step_index, zero fill
  output logic              m_axis_tlast    // last_point
);

  coord_t            ctrl      [NUM_REGS];
  coord_t            ctrl_next [NUM_REGS];
  axis_init_t        init_x, init_y;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[ADDR_W-1:2];
  assign prdata = DATA_W'(ctrl[paddr[ADDR_W-1:2]]);

  always_comb begin
    ctrl_next = ctrl;
    if (wr_en) begin
      ctrl_next[wr_idx] = pwdata[COORD_BITS-1:0];
    end
  end

  // start values follow the registers in the same cycle as the write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        ctrl[i] <= '0;
      end
      init_x <= '0;
      init_y <= '0;
    end else if (wr_en) begin
      ctrl   <= ctrl_next;
      init_x <= axis_init(ctrl_next[REG_X0], ctrl_next[REG_X1],
                          ctrl_next[REG_X2], ctrl_next[REG_X3]);
      init_y <= axis_init(ctrl_next[REG_Y0], ctrl_next[REG_Y1],
                          ctrl_next[REG_Y2], ctrl_next[REG_Y3]);
    end
  end

  // step control
  logic [STEP_W-1:0] step_count, k_cur;
  logic              accept, load, last;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign k_cur  = s_axis_tdata[0] ? '0 : step_count;
  assign load   = (k_cur == '0);
  assign last   = (k_cur == LAST_K);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= '0;
    end else if (accept) begin
      step_count <= last ? '0 : k_cur + 1'b1;
    end
  end

  // difference cells, axis 0 is x, axis 1 is y; cell 0 is the accumulator
  acc_t init_arr [2][4];
  acc_t cur      [2][4];

  assign init_arr[0][0] = init_x.acc;
  assign init_arr[0][1] = init_x.d1;
  assign init_arr[0][2] = init_x.d2;
  assign init_arr[0][3] = init_x.d3;
  assign init_arr[1][0] = init_y.acc;
  assign init_arr[1][1] = init_y.d1;
  assign init_arr[1][2] = init_y.d2;
  assign init_arr[1][3] = init_y.d3;

  for (genvar a = 0; a < 2; a++) begin : g_axis
    for (genvar j = 0; j < 4; j++) begin : g_cell
      acc_t nb;
      if (j == 3) begin : g_end
        assign nb = '0;
      end else begin : g_mid
        assign nb = cur[a][j+1];
      end
      cbps_diff_cell u_cell (
        .clk     (clk),
        .load    (load),
        .advance (accept && !last),
        .init    (init_arr[a][j]),
        .nb_cur  (nb),
        .cur     (cur[a][j])
      );
    end
  end

  // rounding row: floor((2*acc + N^3) / (2*N^3)), most significant bit first
  div_lane_t lane  [COORD_BITS+1];
  logic      valid [COORD_BITS+1];
  logic      ready [COORD_BITS+1];

  always_comb begin
    lane[0]       = '0;
    lane[0].rem_x = cur[0][0];
    lane[0].rem_y = cur[1][0];
    lane[0].step  = k_cur;
    lane[0].last  = last;
  end

  assign valid[0]            = s_axis_tvalid;
  assign s_axis_tready       = ready[0];
  assign ready[COORD_BITS]   = m_axis_tready;

  for (genvar i = 0; i < COORD_BITS; i++) begin : g_div
    localparam acc_t DIV = N3A << (COORD_BITS - i);
    cbps_div_cell u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .in_lane   (lane[i]),
      .divisor   (DIV),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .out_lane  (lane[i+1])
    );
  end

  assign m_axis_tvalid = valid[COORD_BITS];
  assign m_axis_tdata  = OUT_W'({lane[COORD_BITS].step, lane[COORD_BITS].q_y,
                                 lane[COORD_BITS].q_x});
  assign m_axis_tlast  = lane[COORD_BITS].last;

endmodule
